/* hdl/assert_macros.svh */
// Assertion helpers of the frame decoder, used by rfd_parser.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is held.
`define RFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RFD_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define RFD_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rfd_pkg.sv */
// Shared types, codes and constants of the frame decoder.
// No dependencies; imported by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    // Default length width of the header length fields.
    localparam int RFD_LEN_BITS = 16;

    // Fixed overhead bytes of a frame beside the three fields and payload.
    localparam int FIXED_BYTES = 26;

    // Width of the length fields on the result word.
    localparam int OUT_LEN_W = 16;

    // Configuration port shape.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd2;

    localparam logic [7:0]  START_BYTE_RST = 8'd2;
    localparam logic [7:0]  END_BYTE_RST   = 8'd3;
    localparam logic [15:0] MAX_LEN_RST    = 16'hFFFF;

    // Result kinds.
    localparam logic KIND_CONTENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Field tags of content bytes.
    localparam logic [1:0] TAG_REQ_ID  = 2'd0;
    localparam logic [1:0] TAG_METHOD  = 2'd1;
    localparam logic [1:0] TAG_ERRINFO = 2'd2;
    localparam logic [1:0] TAG_PAYLOAD = 2'd3;

    // Summary status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_END = 2'd1;
    localparam logic [1:0] ST_LEN_ERR = 2'd2;
    localparam logic [1:0] ST_OVERRUN = 2'd3;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [15:0] max_frame_len;
    } cfg_t;

    typedef struct packed {
        logic                  result_kind;
        logic [1:0]            field_tag;
        logic [7:0]            out_byte;
        logic                  last;
        logic [1:0]            status;
        logic [OUT_LEN_W-1:0]  frame_len;
        logic [OUT_LEN_W-1:0]  req_id_len;
        logic [OUT_LEN_W-1:0]  method_len;
        logic [OUT_LEN_W-1:0]  err_info_len;
        logic [OUT_LEN_W-1:0]  payload_len;
        logic signed [31:0]    err_code;
        logic [31:0]           checksum_word;
    } result_t;

endpackage

`default_nettype wire

/* hdl/rfd_if.sv */
// Stream interfaces of the frame decoder: received bytes and result words.
// Depends on rfd_pkg for the length field width.
`timescale 1ns / 1ps
`default_nettype none

interface rfd_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rfd_result_if import rfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 result_kind;
    logic [1:0]           field_tag;
    logic [7:0]           out_byte;
    logic                 last;
    logic [1:0]           status;
    logic [OUT_LEN_W-1:0] frame_len;
    logic [OUT_LEN_W-1:0] req_id_len;
    logic [OUT_LEN_W-1:0] method_len;
    logic [OUT_LEN_W-1:0] err_info_len;
    logic [OUT_LEN_W-1:0] payload_len;
    logic signed [31:0]   err_code;
    logic [31:0]          checksum_word;

    modport source (
        output valid, output result_kind, output field_tag, output out_byte,
        output last, output status, output frame_len, output req_id_len,
        output method_len, output err_info_len, output payload_len,
        output err_code, output checksum_word, input ready
    );
    modport sink (
        input valid, input result_kind, input field_tag, input out_byte,
        input last, input status, input frame_len, input req_id_len,
        input method_len, input err_info_len, input payload_len,
        input err_code, input checksum_word, output ready
    );
endinterface

`default_nettype wire

/* hdl/rpc_frame_decoder.sv */
// Channel   Dir   Payload                                  Handshake
// stream    in    data_byte[7:0]                           valid/ready
// result    out   kind, tag, byte, last, status, header    valid/ready
// cfg       in    cfg_index[1:0], cfg_data[15:0]           cfg_we, no wait
//
// One byte is taken per clock; a result word appears in the cycle after its byte.
// The single result register sets the rate: a new byte is taken whenever that
// register is empty or its word leaves in the same cycle.
// A stall on result holds the result register and, once it is full, stream.ready.
// Reset is asynchronous: the decoder hunts for a start byte, registers default.
// Top level of the frame decoder. Depends on rfd_pkg, rfd_if and the rfd_ modules.
`timescale 1ns / 1ps
`default_nettype none

module rpc_frame_decoder import rfd_pkg::*;
#(
    parameter int LEN_BITS = RFD_LEN_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rfd_byte_if.sink                   stream,
    rfd_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    up_ready;
    logic    accept;

    assign stream.ready = up_ready;
    assign accept       = stream.valid && up_ready;

    rfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .data_byte (stream.data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    rfd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && res_valid),
        .res      (res),
        .up_ready (up_ready),
        .result   (result)
    );

endmodule

`default_nettype wire

/* hdl/rfd_cfg_regs.sv */
// Configuration registers of the frame decoder (start byte, end byte, max length).
// Depends on rfd_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module rfd_cfg_regs import rfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes change nothing
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE: cfg_next.start_byte    = cfg_data[7:0];
                CFG_END_BYTE:   cfg_next.end_byte      = cfg_data[7:0];
                CFG_MAX_LEN:    cfg_next.max_frame_len = cfg_data[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= START_BYTE_RST;
            cfg_reg.end_byte      <= END_BYTE_RST;
            cfg_reg.max_frame_len <= MAX_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/rfd_parser.sv */
// Frame parser: phase register, counters and header registers, advanced one
// byte per accepted word. Depends on rfd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rfd_parser import rfd_pkg::*;
#(
    parameter int LEN_BITS = RFD_LEN_BITS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    output logic            res_valid,
    output result_t         res
);

    // Stored lengths never need more than the shown width.
    localparam int LEN_W = (LEN_BITS < OUT_LEN_W) ? LEN_BITS : OUT_LEN_W;
    localparam int SUM_W = 34;

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_LEN     = 4'd1;
    localparam logic [3:0] PH_IDLEN   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_NAMELEN = 4'd4;
    localparam logic [3:0] PH_NAME    = 4'd5;
    localparam logic [3:0] PH_CODE    = 4'd6;
    localparam logic [3:0] PH_INFOLEN = 4'd7;
    localparam logic [3:0] PH_INFO    = 4'd8;
    localparam logic [3:0] PH_PAYLOAD = 4'd9;
    localparam logic [3:0] PH_CHECK   = 4'd10;
    localparam logic [3:0] PH_END     = 4'd11;

    logic [3:0]       phase_reg,    phase_next;
    logic [1:0]       byte_idx_reg, byte_idx_next;
    logic [LEN_W-1:0] count_reg,    count_next;
    logic [23:0]      shift_reg,    shift_next;
    logic [LEN_W-1:0] total_reg,    total_next;
    logic [LEN_W-1:0] id_len_reg,   id_len_next;
    logic [LEN_W-1:0] name_len_reg, name_len_next;
    logic [LEN_W-1:0] info_len_reg, info_len_next;
    logic [LEN_W-1:0] data_len_reg, data_len_next;
    logic [31:0]      code_reg,     code_next;
    logic [31:0]      check_reg,    check_next;

    logic [31:0]      word;
    logic [LEN_W-1:0] word_sat;
    logic [LEN_W-1:0] count_dec;
    logic [SUM_W-1:0] used;
    logic             sum_fire;
    logic [1:0]       sum_status;
    logic             is_data_phase;

    // Clamp a received length to the length maximum, keep the stored bits
    function automatic logic [LEN_W-1:0] sat_len(input logic [31:0] v);
        logic over;
        over = (v >> LEN_BITS) != 32'd0;
        return over ? {LEN_W{1'b1}} : v[LEN_W-1:0];
    endfunction

    assign word      = {shift_reg, data_byte};
    assign word_sat  = sat_len(word);
    assign count_dec = count_reg - LEN_W'(1);

    assign is_data_phase = (phase_reg == PH_ID) || (phase_reg == PH_NAME) ||
                           (phase_reg == PH_INFO) || (phase_reg == PH_PAYLOAD);

    // Advance the parse by one byte
    always_comb
    begin
        phase_next    = phase_reg;
        byte_idx_next = byte_idx_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        total_next    = total_reg;
        id_len_next   = id_len_reg;
        name_len_next = name_len_reg;
        info_len_next = info_len_reg;
        data_len_next = data_len_reg;
        code_next     = code_reg;
        check_next    = check_reg;
        used          = '0;
        sum_fire      = 1'b0;
        sum_status    = ST_OK;
        res_valid     = 1'b0;
        res           = '0;

        if (phase_reg == PH_HUNT || phase_reg > PH_END)
        begin
            // Hunt for the start byte, clear the header on a hit
            phase_next = PH_HUNT;
            if (data_byte == cfg.start_byte)
            begin
                total_next    = '0;
                id_len_next   = '0;
                name_len_next = '0;
                info_len_next = '0;
                data_len_next = '0;
                code_next     = '0;
                check_next    = '0;
                byte_idx_next = '0;
                phase_next    = PH_LEN;
            end
        end
        else if (is_data_phase)
        begin
            // Pass a content byte, tagged by its field
            res_valid        = 1'b1;
            res.result_kind  = KIND_CONTENT;
            res.out_byte     = data_byte;
            case (phase_reg)
                PH_ID:   res.field_tag = TAG_REQ_ID;
                PH_NAME: res.field_tag = TAG_METHOD;
                PH_INFO: res.field_tag = TAG_ERRINFO;
                default: res.field_tag = TAG_PAYLOAD;
            endcase
            count_next = count_dec;
            if (count_dec == '0)
            begin
                byte_idx_next = '0;
                case (phase_reg)
                    PH_ID:   phase_next = PH_NAMELEN;
                    PH_NAME: phase_next = PH_CODE;
                    PH_INFO:
                    begin
                        if (data_len_reg != '0)
                        begin
                            phase_next = PH_PAYLOAD;
                            count_next = data_len_reg;
                        end
                        else
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    default: phase_next = PH_CHECK;
                endcase
            end
        end
        else if (phase_reg == PH_END)
        begin
            // Close the frame on the end byte
            sum_fire   = 1'b1;
            sum_status = (data_byte == cfg.end_byte) ? ST_OK : ST_BAD_END;
        end
        else
        begin
            // Shift in one byte of a big-endian header word
            shift_next    = word[23:0];
            byte_idx_next = byte_idx_reg + 2'd1;
            if (byte_idx_reg == 2'd3)
            begin
                byte_idx_next = '0;
                case (phase_reg)
                    PH_LEN:
                    begin
                        total_next = word_sat;
                        if (word < 32'(FIXED_BYTES) ||
                            word > 32'(cfg.max_frame_len) ||
                            (word >> LEN_BITS) != 32'd0)
                        begin
                            sum_fire   = 1'b1;
                            sum_status = ST_LEN_ERR;
                        end
                        else
                        begin
                            phase_next = PH_IDLEN;
                        end
                    end
                    PH_IDLEN:
                    begin
                        id_len_next = word_sat;
                        used = SUM_W'(FIXED_BYTES) + SUM_W'(word);
                        if (used > SUM_W'(total_reg))
                        begin
                            sum_fire   = 1'b1;
                            sum_status = ST_OVERRUN;
                        end
                        else if (word != 32'd0)
                        begin
                            phase_next = PH_ID;
                            count_next = word[LEN_W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_NAMELEN;
                        end
                    end
                    PH_NAMELEN:
                    begin
                        name_len_next = word_sat;
                        used = SUM_W'(FIXED_BYTES) + SUM_W'(id_len_reg) + SUM_W'(word);
                        if (used > SUM_W'(total_reg))
                        begin
                            sum_fire   = 1'b1;
                            sum_status = ST_OVERRUN;
                        end
                        else if (word != 32'd0)
                        begin
                            phase_next = PH_NAME;
                            count_next = word[LEN_W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                    PH_CODE:
                    begin
                        code_next  = word;
                        phase_next = PH_INFOLEN;
                    end
                    PH_INFOLEN:
                    begin
                        info_len_next = word_sat;
                        used = SUM_W'(FIXED_BYTES) + SUM_W'(id_len_reg) +
                               SUM_W'(name_len_reg) + SUM_W'(word);
                        if (used > SUM_W'(total_reg))
                        begin
                            sum_fire   = 1'b1;
                            sum_status = ST_OVERRUN;
                        end
                        else
                        begin
                            data_len_next = total_reg - used[LEN_W-1:0];
                            if (word != 32'd0)
                            begin
                                phase_next = PH_INFO;
                                count_next = word[LEN_W-1:0];
                            end
                            else if (data_len_next != '0)
                            begin
                                phase_next = PH_PAYLOAD;
                                count_next = data_len_next;
                            end
                            else
                            begin
                                phase_next = PH_CHECK;
                            end
                        end
                    end
                    PH_CHECK:
                    begin
                        check_next = word;
                        phase_next = PH_END;
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end

        // Build the summary from the updated header and resume hunting
        if (sum_fire)
        begin
            phase_next        = PH_HUNT;
            res_valid         = 1'b1;
            res.result_kind   = KIND_SUMMARY;
            res.last          = 1'b1;
            res.status        = sum_status;
            res.frame_len     = OUT_LEN_W'(total_next);
            res.req_id_len    = OUT_LEN_W'(id_len_next);
            res.method_len    = OUT_LEN_W'(name_len_next);
            res.err_info_len  = OUT_LEN_W'(info_len_next);
            res.payload_len   = OUT_LEN_W'(data_len_next);
            res.err_code      = code_next;
            res.checksum_word = check_next;
        end
    end

    // Hold state unless a byte is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            byte_idx_reg <= '0;
            count_reg    <= '0;
            shift_reg    <= '0;
            total_reg    <= '0;
            id_len_reg   <= '0;
            name_len_reg <= '0;
            info_len_reg <= '0;
            data_len_reg <= '0;
            code_reg     <= '0;
            check_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            byte_idx_reg <= byte_idx_next;
            count_reg    <= count_next;
            shift_reg    <= shift_next;
            total_reg    <= total_next;
            id_len_reg   <= id_len_next;
            name_len_reg <= name_len_next;
            info_len_reg <= info_len_next;
            data_len_reg <= data_len_next;
            code_reg     <= code_next;
            check_reg    <= check_next;
        end
    end

    // A data phase always has bytes left to pass
    `RFD_ASSERT_IMPLY(a_data_count, clk, rst_n, is_data_phase, count_reg != '0, "data phase with zero count")
    // A summary always drops back to hunting
    `RFD_ASSERT_NEXT(a_sum_hunt, clk, rst_n, accept && res_valid && res.result_kind == KIND_SUMMARY, phase_reg == PH_HUNT, "no hunt after summary")
    // Content bytes come only from data phases
    `RFD_ASSERT(a_content_src, clk, rst_n, !(res_valid && res.result_kind == KIND_CONTENT) || is_data_phase, "content byte outside a data field")

endmodule

`default_nettype wire

/* hdl/rfd_out_stage.sv */
// Result register between the parser and the result channel.
// Depends on rfd_pkg (result_t) and rfd_if (rfd_result_if).
`timescale 1ns / 1ps
`default_nettype none

module rfd_out_stage import rfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire result_t  res,
    output logic          up_ready,
    rfd_result_if.source  result
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Take a new byte while empty or while the held word leaves
    assign up_ready   = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload only on a new result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid         = valid_reg;
    assign result.result_kind   = data_reg.result_kind;
    assign result.field_tag     = data_reg.field_tag;
    assign result.out_byte      = data_reg.out_byte;
    assign result.last          = data_reg.last;
    assign result.status        = data_reg.status;
    assign result.frame_len     = data_reg.frame_len;
    assign result.req_id_len    = data_reg.req_id_len;
    assign result.method_len    = data_reg.method_len;
    assign result.err_info_len  = data_reg.err_info_len;
    assign result.payload_len   = data_reg.payload_len;
    assign result.err_code      = data_reg.err_code;
    assign result.checksum_word = data_reg.checksum_word;

endmodule

`default_nettype wire

/* sim/rfd_result_check.sv */
// Result checker of the frame decoder: predicts every result word from the bytes taken.
// Watches the stream, result and register channels; depends on rfd_pkg and rfd_if.
`timescale 1ns / 1ps

module rfd_result_check import rfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rfd_byte_if                   stream,
    rfd_result_if                 result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  drain_done,
    output int                    pending,
    output int                    fail_count
);

    typedef enum logic [3:0] {
        S_HUNT, S_TOTAL, S_IDLEN, S_ID, S_NAMELEN, S_NAME,
        S_CODE, S_INFOLEN, S_INFO, S_PAYLOAD, S_CHECK, S_END
    } parse_state_e;

    // Register copy and parser state
    cfg_t                regs;
    parse_state_e        state;
    logic [15:0]         count;
    logic [31:0]         shift;
    logic [15:0]         tot_len;
    logic [15:0]         id_len;
    logic [15:0]         name_len;
    logic [15:0]         info_len;
    logic [15:0]         pay_len;
    logic signed [31:0]  code;
    logic [31:0]         check_word;

    result_t             decoded_q[$];
    int                  result_idx;
    bit                  drained;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void start_word(input parse_state_e nxt);
        state = nxt;
        count = '0;
        shift = '0;
    endfunction

    function automatic void start_payload();
        if (pay_len != 0)
        begin
            state = S_PAYLOAD;
            count = pay_len;
        end
        else
            start_word(S_CHECK);
    endfunction

    // Advance the parser by one byte; return 1 with the result word it causes
    function automatic bit decode_byte(input logic [7:0] b, output result_t r);
        logic [31:0] w;
        logic [33:0] used;
        bit          done;
        logic [1:0]  st;
        r = '0;
        done = 1'b0;
        st = ST_OK;
        case (state)
            S_HUNT:
            begin
                if (b == regs.start_byte)
                begin
                    tot_len = '0;
                    id_len = '0;
                    name_len = '0;
                    info_len = '0;
                    pay_len = '0;
                    code = '0;
                    check_word = '0;
                    start_word(S_TOTAL);
                end
                return 1'b0;
            end
            S_ID, S_NAME, S_INFO, S_PAYLOAD:
            begin
                r.result_kind = KIND_CONTENT;
                case (state)
                    S_ID:    r.field_tag = TAG_REQ_ID;
                    S_NAME:  r.field_tag = TAG_METHOD;
                    S_INFO:  r.field_tag = TAG_ERRINFO;
                    default: r.field_tag = TAG_PAYLOAD;
                endcase
                r.out_byte = b;
                if (count != 0)
                    count--;
                if (count == 0)
                begin
                    case (state)
                        S_ID:    start_word(S_NAMELEN);
                        S_NAME:  start_word(S_CODE);
                        S_INFO:  start_payload();
                        default: start_word(S_CHECK);
                    endcase
                end
                return 1'b1;
            end
            S_END:
            begin
                done = 1'b1;
                st = (b == regs.end_byte) ? ST_OK : ST_BAD_END;
            end
            default:
            begin
                // collect a big-endian header word
                shift = {shift[23:0], b};
                count++;
                if (count == 4)
                begin
                    w = shift;
                    case (state)
                        S_TOTAL:
                        begin
                            tot_len = sat16(w);
                            if (w < FIXED_BYTES || w > {16'h0000, regs.max_frame_len})
                            begin
                                done = 1'b1;
                                st = ST_LEN_ERR;
                            end
                            else
                                start_word(S_IDLEN);
                        end
                        S_IDLEN:
                        begin
                            id_len = sat16(w);
                            used = 34'(FIXED_BYTES) + 34'(w);
                            if (used > 34'(tot_len))
                            begin
                                done = 1'b1;
                                st = ST_OVERRUN;
                            end
                            else if (w != 0)
                            begin
                                state = S_ID;
                                count = w[15:0];
                            end
                            else
                                start_word(S_NAMELEN);
                        end
                        S_NAMELEN:
                        begin
                            name_len = sat16(w);
                            used = 34'(FIXED_BYTES) + 34'(id_len) + 34'(w);
                            if (used > 34'(tot_len))
                            begin
                                done = 1'b1;
                                st = ST_OVERRUN;
                            end
                            else if (w != 0)
                            begin
                                state = S_NAME;
                                count = w[15:0];
                            end
                            else
                                start_word(S_CODE);
                        end
                        S_CODE:
                        begin
                            code = w;
                            start_word(S_INFOLEN);
                        end
                        S_INFOLEN:
                        begin
                            info_len = sat16(w);
                            used = 34'(FIXED_BYTES) + 34'(id_len) + 34'(name_len) + 34'(w);
                            if (used > 34'(tot_len))
                            begin
                                done = 1'b1;
                                st = ST_OVERRUN;
                            end
                            else
                            begin
                                pay_len = tot_len - used[15:0];
                                if (w != 0)
                                begin
                                    state = S_INFO;
                                    count = w[15:0];
                                end
                                else
                                    start_payload();
                            end
                        end
                        default:
                        begin
                            check_word = w;
                            state = S_END;
                            count = '0;
                        end
                    endcase
                end
            end
        endcase
        // close the frame attempt with a summary
        if (done)
        begin
            r.result_kind = KIND_SUMMARY;
            r.last = 1'b1;
            r.status = st;
            r.frame_len = tot_len;
            r.req_id_len = id_len;
            r.method_len = name_len;
            r.err_info_len = info_len;
            r.payload_len = pay_len;
            r.err_code = code;
            r.checksum_word = check_word;
            state = S_HUNT;
            count = '0;
        end
        return done;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      result_idx, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_word;
        result_t got;
        if (!rst_n)
        begin
            regs.start_byte = START_BYTE_RST;
            regs.end_byte = END_BYTE_RST;
            regs.max_frame_len = MAX_LEN_RST;
            state = S_HUNT;
            count = '0;
            shift = '0;
            tot_len = '0;
            id_len = '0;
            name_len = '0;
            info_len = '0;
            pay_len = '0;
            code = '0;
            check_word = '0;
            decoded_q.delete();
            result_idx = 0;
            drained = 1'b0;
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_BYTE: regs.start_byte = cfg_data[7:0];
                    CFG_END_BYTE:   regs.end_byte = cfg_data[7:0];
                    CFG_MAX_LEN:    regs.max_frame_len = cfg_data;
                    default:        ;
                endcase
            end

            // predict from each byte word taken
            if (stream.valid && stream.ready)
            begin
                if (decode_byte(stream.data_byte, exp_word))
                    decoded_q = {decoded_q, exp_word};
            end

            // compare each result word taken with the oldest prediction
            if (result.valid && result.ready)
            begin
                got.result_kind = result.result_kind;
                got.field_tag = result.field_tag;
                got.out_byte = result.out_byte;
                got.last = result.last;
                got.status = result.status;
                got.frame_len = result.frame_len;
                got.req_id_len = result.req_id_len;
                got.method_len = result.method_len;
                got.err_info_len = result.err_info_len;
                got.payload_len = result.payload_len;
                got.err_code = result.err_code;
                got.checksum_word = result.checksum_word;
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_idx));
                else
                begin
                    exp_word = decoded_q.pop_front();
                    check_field("result_kind", got.result_kind, exp_word.result_kind);
                    check_field("field_tag", got.field_tag, exp_word.field_tag);
                    check_field("out_byte", got.out_byte, exp_word.out_byte);
                    check_field("last", got.last, exp_word.last);
                    check_field("status", got.status, exp_word.status);
                    check_field("frame_len", got.frame_len, exp_word.frame_len);
                    check_field("req_id_len", got.req_id_len, exp_word.req_id_len);
                    check_field("method_len", got.method_len, exp_word.method_len);
                    check_field("err_info_len", got.err_info_len, exp_word.err_info_len);
                    check_field("payload_len", got.payload_len, exp_word.payload_len);
                    check_field("err_code", got.err_code, exp_word.err_code);
                    check_field("checksum_word", got.checksum_word, exp_word.checksum_word);
                end
                result_idx++;
            end

            // flag predictions still waiting once traffic has drained
            if (drain_done && !drained)
            begin
                drained = 1'b1;
                if (decoded_q.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              decoded_q.size()));
            end

            pending <= decoded_q.size();
        end
    end

endmodule

/* sim/tb_rpc_frame_decoder.sv */
// Testbench top of the frame decoder: directed and random frames under several settings.
// Drives stream, result ready and register writes; rfd_result_check does the comparison.
`timescale 1ns / 1ps

module tb_rpc_frame_decoder;
    import rfd_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_BYTES  = 30;
    localparam int MAX_CONTENT  = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  drain_done;
    int                    pending;
    int                    fail_count;

    // Settings known to the stimulus side, used to build frames
    logic [7:0]            cur_start;
    logic [7:0]            cur_end;
    logic [15:0]           cur_max;
    bit                    calm;
    bit                    hold_off;
    logic [7:0]            byte_q[$];

    rfd_byte_if   stream_ch ();
    rfd_result_if result_ch ();

    rpc_frame_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rfd_result_check result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .drain_done (drain_done),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the decoder hangs
    initial
    begin
        #6_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int sender_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int receiver_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    function automatic int field_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 3);
        if (r < 80)
            return $urandom_range(4, 10);
        if (r < 97)
            return $urandom_range(11, 30);
        return $urandom_range(31, MAX_CONTENT);
    endfunction

    // Receiver: bursts of ready with short and long stalls, one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            result_ch.ready <= 1'b1;
            repeat (calm ? $urandom_range(50, 200) : $urandom_range(1, 16)) @(posedge clk);
            if (!calm)
            begin
                result_ch.ready <= 1'b0;
                repeat (receiver_stall()) @(posedge clk);
            end
        end
    end

    // Append one byte to the send queue
    task automatic append_byte(input logic [7:0] b);
        byte_q = {byte_q, b};
    endtask

    task automatic queue_word(input logic [31:0] w);
        append_byte(w[31:24]);
        append_byte(w[23:16]);
        append_byte(w[15:8]);
        append_byte(w[7:0]);
    endtask

    // Content is capped so that huge declared lengths stay cheap
    task automatic queue_bytes(input logic [31:0] n);
        int cnt;
        cnt = (n > MAX_CONTENT) ? MAX_CONTENT : int'(n);
        repeat (cnt) append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_frame(input logic [31:0] total, input logic [31:0] idl,
                               input logic [31:0] nml, input logic [31:0] code,
                               input logic [31:0] infl, input int pay_n,
                               input logic [31:0] chk, input logic [7:0] endb);
        append_byte(cur_start);
        queue_word(total);
        queue_word(idl);
        queue_bytes(idl);
        queue_word(nml);
        queue_bytes(nml);
        queue_word(code);
        queue_word(infl);
        queue_bytes(infl);
        queue_bytes(pay_n);
        queue_word(chk);
        append_byte(endb);
    endtask

    // Good frame, bad end byte on bad_end; empty fields most times cur_max would reject it
    task automatic queue_good_frame(input bit bad_end);
        int idn;
        int nmn;
        int ifn;
        int pyn;
        idn = field_len();
        nmn = field_len();
        ifn = field_len();
        pyn = field_len();
        if (FIXED_BYTES + idn + nmn + ifn + pyn > int'(cur_max) && $urandom_range(0, 4) != 0)
        begin
            idn = 0;
            nmn = 0;
            ifn = 0;
            pyn = 0;
        end
        queue_frame(FIXED_BYTES + idn + nmn + ifn + pyn, idn, nmn, $urandom(), ifn, pyn,
                    $urandom(), bad_end ? cur_end ^ 8'($urandom_range(1, 255)) : cur_end);
    endtask

    task automatic queue_bad_frame();
        int          room;
        int          a;
        int          x;
        int          y;
        logic [31:0] total;
        room = int'(cur_max) - FIXED_BYTES;
        a = $urandom_range(0, (room > 20) ? 20 : room);
        total = FIXED_BYTES + a;
        x = $urandom_range(0, a);
        y = $urandom_range(0, a - x);
        case ($urandom_range(0, 5))
            0: queue_frame($urandom_range(0, FIXED_BYTES - 1), 0, 0, $urandom(), 0, 0,
                           $urandom(), cur_end);
            1:
            begin
                if (cur_max == 16'hFFFF)
                    total = 32'h0001_0000 | $urandom();
                else
                    total = $urandom_range(int'(cur_max) + 1, 65535);
                queue_frame(total, 0, 0, $urandom(), 0, 0, $urandom(), cur_end);
            end
            2: queue_frame(total, a + 1 + $urandom_range(0, 5), 0, $urandom(), 0, 0,
                           $urandom(), cur_end);
            3: queue_frame(total, x, a - x + 1 + $urandom_range(0, 5), $urandom(), 0, 0,
                           $urandom(), cur_end);
            4: queue_frame(total, x, y, $urandom(), a - x - y + 1 + $urandom_range(0, 5), 0,
                           $urandom(), cur_end);
            default: queue_good_frame(1'b1);
        endcase
    endtask

    // Mostly well-formed frames; the rest broken, cut short or line noise
    task automatic queue_random_traffic(input int budget);
        int kind;
        int mark;
        int cut;
        while (byte_q.size() < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 68)
                queue_good_frame($urandom_range(0, 9) == 0);
            else if (kind < 84)
                queue_bad_frame();
            else if (kind < 93)
                repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
            else
            begin
                mark = byte_q.size();
                queue_good_frame(1'b0);
                cut = $urandom_range(1, byte_q.size() - mark - 1);
                repeat (cut) void'(byte_q.pop_back());
            end
        end
    endtask

    // Offer queued byte words one by one with random gaps
    task automatic send_all();
        logic [7:0] b;
        int         gap;
        while (byte_q.size() != 0)
        begin
            b = byte_q.pop_front();
            gap = sender_gap();
            if (gap != 0)
            begin
                stream_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            stream_ch.valid <= 1'b1;
            stream_ch.data_byte <= b;
            @(posedge clk);
            while (!stream_ch.ready) @(posedge clk);
        end
        stream_ch.valid <= 1'b0;
    endtask

    // Wait for every predicted word to leave, then let the pipeline empty
    task automatic settle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] sb, input logic [7:0] eb,
                              input logic [15:0] ml);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_data <= {8'($urandom_range(0, 255)), sb};
        @(posedge clk);
        cfg_index <= CFG_END_BYTE;
        cfg_data <= {8'($urandom_range(0, 255)), eb};
        @(posedge clk);
        cfg_index <= CFG_MAX_LEN;
        cfg_data <= ml;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_start = sb;
        cur_end = eb;
        cur_max = ml;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_START_BYTE;
        cfg_data = '0;
        drain_done = 1'b0;
        stream_ch.valid = 1'b0;
        stream_ch.data_byte = 8'h00;
        cur_start = START_BYTE_RST;
        cur_end = END_BYTE_RST;
        cur_max = MAX_LEN_RST;
        calm = 1'b0;
        hold_off = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset settings
        append_byte(8'h00);
        append_byte(8'hFF);
        // all fields empty
        queue_frame(FIXED_BYTES, 0, 0, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF, END_BYTE_RST);
        // every field tag present
        queue_frame(FIXED_BYTES + 11, 3, 2, 32'h7FFF_FFFF, 2, 4, 32'h0, END_BYTE_RST);
        // error info but no payload
        queue_frame(FIXED_BYTES + 5, 0, 0, 32'h1, 5, 0, $urandom(), END_BYTE_RST);
        // wrong end byte
        queue_frame(FIXED_BYTES + 1, 0, 0, 32'hFFFF_FFFF, 0, 1, $urandom(), 8'hFF);
        // total below the fixed overhead
        queue_frame(FIXED_BYTES - 1, 0, 0, 0, 0, 0, 0, END_BYTE_RST);
        // total above the length width
        queue_frame(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, END_BYTE_RST);
        // start values inside a rejected header are not rescanned
        queue_frame(32'h0202_0202, 32'h0202_0202, 0, 0, 0, 0, 0, END_BYTE_RST);
        // request id overrun at the largest total
        queue_frame(32'h0000_FFFF, 65510, 0, 0, 0, 0, 0, END_BYTE_RST);
        // request id length above the length width
        queue_frame(32'h0000_FFFF, 32'h0001_0000, 0, 0, 0, 0, 0, END_BYTE_RST);
        // method name overrun
        queue_frame(40, 4, 11, 0, 0, 0, 0, END_BYTE_RST);
        // error info overrun
        queue_frame(40, 2, 2, 32'h1234_5678, 11, 0, 0, END_BYTE_RST);
        // fields that fill the frame exactly
        queue_frame(40, 4, 4, 32'hDEAD_BEEF, 6, 0, $urandom(), END_BYTE_RST);
        send_all();
        settle();

        // Random traffic under several register settings
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: write_regs(8'h00, 8'hFF, 16'hFFFF);
                1: write_regs(8'hFF, 8'h00, 16'd26);
                2: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(26, 300)));
                3: write_regs(8'hA5, 8'h5A, 16'd1000);
                4: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(26, 65535)));
                default: write_regs(START_BYTE_RST, END_BYTE_RST, MAX_LEN_RST);
            endcase
            calm = (p == 3);
            if (p == 2)
                hold_off = 1'b1;
            queue_random_traffic(PHASE_BYTES);
            send_all();
            settle();
        end

        drain_done <= 1'b1;
        repeat (3) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
